// File: rtl/tsg_pkg.sv
package tsg_pkg;

	localparam int COORD_BITS = 12;
	localparam int SCREEN_W   = 8;
	localparam int TIME_W     = 32;
	localparam int COOL_W     = 16;
	localparam int SWIPE_W    = 12;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int SUM_W = SQ_W + 1;
	localparam int LIM_W = 2 * SWIPE_W;
	localparam int CMP_W = (SUM_W > LIM_W) ? SUM_W : LIM_W;

	localparam logic [COOL_W-1:0]   COOLDOWN_RST = COOL_W'(100);
	localparam logic [SWIPE_W-1:0]  SWIPE_RST    = SWIPE_W'(100);
	localparam logic [SCREEN_W-1:0] SCREENS_RST  = SCREEN_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COOLDOWN = 2'd0,
		REG_SWIPE    = 2'd1,
		REG_SCREENS  = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		GEST_NONE = 2'd0,
		GEST_UP   = 2'd1,
		GEST_RTL  = 2'd2,
		GEST_LTR  = 2'd3
	} gesture_t;

	typedef struct packed {
		logic [COOL_W-1:0]   cooldown;
		logic [LIM_W-1:0]    lim;
		logic [SCREEN_W-1:0] screens;
	} cfg_t;

	typedef struct packed {
		logic [SCREEN_W-1:0]   screen;
		logic                  touched;
		logic [COORD_BITS-1:0] px;
		logic [COORD_BITS-1:0] py;
		logic [TIME_W-1:0]     now;
	} item_t;

	typedef struct packed {
		logic [SCREEN_W-1:0] screen;
		gesture_t            gesture;
		logic                refresh;
	} result_t;

endpackage

// File: rtl/tsg_classify.sv
module tsg_classify import tsg_pkg::*; (
	input  logic [COORD_BITS-1:0] start_x,
	input  logic [COORD_BITS-1:0] start_y,
	input  logic [COORD_BITS-1:0] end_x,
	input  logic [COORD_BITS-1:0] end_y,
	input  logic [LIM_W-1:0]      lim,
	output gesture_t              gesture
);

	logic [COORD_BITS-1:0] adx, ady;
	logic                  xpos, xneg, ypos;
	logic [SQ_W-1:0]       sqx, sqy;
	logic [CMP_W-1:0]      travel_sq, lim_ext;

	always_comb begin
		xpos = end_x > start_x;
		xneg = end_x < start_x;
		ypos = end_y > start_y;
		adx  = xpos ? end_x - start_x : start_x - end_x;
		ady  = ypos ? end_y - start_y : start_y - end_y;
		sqx  = SQ_W'(adx) * SQ_W'(adx);
		sqy  = SQ_W'(ady) * SQ_W'(ady);
		travel_sq = CMP_W'(sqx) + CMP_W'(sqy);
		lim_ext = CMP_W'(lim);

		gesture = GEST_NONE;
		if (travel_sq >= lim_ext) begin
			// zero travel only gets here with a zero threshold
			if ((ypos && adx < ady) || (adx == '0 && ady == '0)) begin
				gesture = GEST_UP;
			end else if (xpos && ady < adx) begin
				gesture = GEST_RTL;
			end else if (xneg && ady < adx) begin
				gesture = GEST_LTR;
			end
		end
	end

endmodule

// File: rtl/tsg_step.sv
module tsg_step import tsg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    advance,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	logic [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic                  was_touched_q;
	logic [TIME_W-1:0]     deadline_q;

	logic     active, expired, stroke_end;
	gesture_t stroke_gesture;

	tsg_classify u_classify (
		.start_x (start_x_q),
		.start_y (start_y_q),
		.end_x   (end_x_q),
		.end_y   (end_y_q),
		.lim     (cfg.lim),
		.gesture (stroke_gesture)
	);

	always_comb begin
		active     = item.screen != '0;
		expired    = item.now >= deadline_q;
		stroke_end = active && !item.touched && expired && was_touched_q;

		res.screen  = item.screen;
		res.gesture = GEST_NONE;
		res.refresh = active && !item.touched && expired;
		if (stroke_end) begin
			res.gesture = stroke_gesture;
			case (stroke_gesture)
				GEST_RTL: begin
					if (item.screen < cfg.screens) res.screen = item.screen + SCREEN_W'(1);
					res.refresh = 1'b1;
				end
				GEST_LTR: begin
					if (item.screen > SCREEN_W'(1)) res.screen = item.screen - SCREEN_W'(1);
					res.refresh = 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q     <= '1;
			start_y_q     <= '1;
			end_x_q       <= '1;
			end_y_q       <= '1;
			was_touched_q <= 1'b0;
			deadline_q    <= '0;
		end else if (advance && active) begin
			if (item.touched) begin
				if (!was_touched_q) begin
					start_x_q <= item.px;
					start_y_q <= item.py;
				end
				was_touched_q <= 1'b1;
				end_x_q       <= item.px;
				end_y_q       <= item.py;
				deadline_q    <= item.now + TIME_W'(cfg.cooldown);
			end else if (stroke_end) begin
				was_touched_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/touch_swipe_gesture_detector.sv
// Path: an accepted input beat goes through the input register, then the step
// logic into the result register, before it leaves as its result beat.
// Throughput: one poll per cycle, limited only by the result register draining.
// Reset: arst_n clears both valid flags, the stroke state (points to all ones,
// no touch, deadline 0) and the registers to cooldown 100, distance 100, 4 screens.
module touch_swipe_gesture_detector import tsg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [SCREEN_W-1:0]   current_screen,
	input  logic                  touched,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  logic [TIME_W-1:0]     now_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SCREEN_W-1:0]   new_screen,
	output logic [1:0]            gesture,
	output logic                  refresh_request
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t res, res_s2;
	logic    valid_s2;
	logic    advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cooldown <= COOLDOWN_RST;
			cfg_q.lim      <= LIM_W'(SWIPE_RST) * LIM_W'(SWIPE_RST);
			cfg_q.screens  <= SCREENS_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COOLDOWN: cfg_q.cooldown <= cfg_wdata[COOL_W-1:0];
				// keep the squared threshold so the compare needs no square root
				REG_SWIPE: cfg_q.lim <= LIM_W'(cfg_wdata[SWIPE_W-1:0])
					* LIM_W'(cfg_wdata[SWIPE_W-1:0]);
				REG_SCREENS: cfg_q.screens <= cfg_wdata[SCREEN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) valid_s2 <= 1'b1;
			else if (out_ready) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.screen  <= current_screen;
			item_s1.touched <= touched;
			item_s1.px      <= point_x;
			item_s1.py      <= point_y;
			item_s1.now     <= now_ms;
		end
		if (advance) res_s2 <= res;
	end

	tsg_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

	assign out_valid       = valid_s2;
	assign new_screen      = res_s2.screen;
	assign gesture         = res_s2.gesture;
	assign refresh_request = res_s2.refresh;

	a_side_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (gesture == GEST_RTL || gesture == GEST_LTR) |-> refresh_request)
		else $error("sideways swipe without refresh");

	a_off_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_screen == '0 |-> gesture == GEST_NONE && !refresh_request)
		else $error("activity while detection is off");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("input stage lost a stalled beat");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("result register not loaded");

endmodule

// File: test/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsg_pkg::*;

	localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
	localparam int QUIET_LIMIT = 2000;

	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  cfg_we          = 1'b0;
	reg_idx_t              cfg_index       = REG_COOLDOWN;
	logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
	logic                  in_valid        = 1'b0;
	logic                  in_ready;
	logic [SCREEN_W-1:0]   current_screen  = '0;
	logic                  touched         = 1'b0;
	logic [COORD_BITS-1:0] point_x         = '0;
	logic [COORD_BITS-1:0] point_y         = '0;
	logic [TIME_W-1:0]     now_ms          = '0;
	logic                  out_valid;
	logic                  out_ready       = 1'b0;
	logic [SCREEN_W-1:0]   new_screen;
	logic [1:0]            gesture;
	logic                  refresh_request;

	touch_swipe_gesture_detector uut (.*);

	// Mirror of the detector: registers and stroke state
	logic [COOL_W-1:0]     cooldown_cfg = COOLDOWN_RST;
	logic [SWIPE_W-1:0]    travel_min   = SWIPE_RST;
	logic [SCREEN_W-1:0]   screen_max   = SCREENS_RST;
	logic [COORD_BITS-1:0] press_x      = '1;
	logic [COORD_BITS-1:0] press_y      = '1;
	logic [COORD_BITS-1:0] last_x       = '1;
	logic [COORD_BITS-1:0] last_y       = '1;
	logic                  finger_down  = 1'b0;
	logic [TIME_W-1:0]     hold_until   = '0;

	result_t results_due[$];
	int faults = 0;
	int polls_sent = 0;
	int quiet_cycles = 0;
	logic in_gaps = 1'b1;
	logic out_stalls = 1'b1;
	logic [TIME_W-1:0] clock_now = '0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic result_t classify_poll(item_t p);
		result_t r;
		logic held;
		logic [COORD_BITS-1:0] adx, ady;
		longint unsigned travel, floor_sq;
		r.screen = p.screen;
		r.gesture = GEST_NONE;
		r.refresh = 1'b0;
		if (p.screen != '0) begin
			held = 1'b1;
			if (p.touched) begin
				if (!finger_down) begin
					press_x = p.px;
					press_y = p.py;
					finger_down = 1'b1;
				end
				last_x = p.px;
				last_y = p.py;
				hold_until = p.now + TIME_W'(cooldown_cfg);
			end else if (p.now >= hold_until) begin
				r.refresh = 1'b1;
				held = 1'b0;
			end
			// stroke ends: classify the travel from press point to last point
			if (!held && finger_down) begin
				adx = (last_x >= press_x) ? last_x - press_x : press_x - last_x;
				ady = (last_y >= press_y) ? last_y - press_y : press_y - last_y;
				travel = 64'(adx) * 64'(adx) + 64'(ady) * 64'(ady);
				floor_sq = 64'(travel_min) * 64'(travel_min);
				if (travel >= floor_sq) begin
					if ((last_y > press_y && adx < ady) || (adx == '0 && ady == '0)) begin
						r.gesture = GEST_UP;
					end else if (last_x > press_x && ady < adx) begin
						r.gesture = GEST_RTL;
						if (r.screen < screen_max) r.screen = r.screen + SCREEN_W'(1);
						r.refresh = 1'b1;
					end else if (last_x < press_x && ady < adx) begin
						r.gesture = GEST_LTR;
						if (r.screen > SCREEN_W'(1)) r.screen = r.screen - SCREEN_W'(1);
						r.refresh = 1'b1;
					end
				end
				finger_down = 1'b0;
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("result beat with nothing expected: screen %0d gesture %0d refresh %0d",
					new_screen, gesture, refresh_request);
				faults++;
			end else begin
				want = results_due.pop_front();
				if (new_screen !== want.screen) begin
					$error("new_screen: expected %0d, got %0d", want.screen, new_screen);
					faults++;
				end
				if (gesture !== want.gesture) begin
					$error("gesture: expected %0d, got %0d", want.gesture, gesture);
					faults++;
				end
				if (refresh_request !== want.refresh) begin
					$error("refresh_request: expected %0d, got %0d", want.refresh,
						refresh_request);
					faults++;
				end
			end
		end
		out_ready <= !(out_stalls && $urandom_range(99) < 16);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("tb: done, errors");
		$finish;
	end

	task automatic poll(input logic [SCREEN_W-1:0] scr, input logic tch,
		input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y,
		input logic [TIME_W-1:0] at);
		item_t beat;
		beat = '{scr, tch, x, y, at};
		while (in_gaps && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		current_screen <= scr;
		touched <= tch;
		point_x <= x;
		point_y <= y;
		now_ms <= at;
		do @(posedge clk); while (!in_ready);
		results_due.push_back(classify_poll(beat));
		polls_sent++;
	endtask

	// drop valid and drain every outstanding result
	task automatic settle();
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
	endtask

	task automatic configure(input logic [COOL_W-1:0] cd, input logic [SWIPE_W-1:0] sw,
		input logic [SCREEN_W-1:0] sc);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_COOLDOWN;
		cfg_wdata <= cd;
		@(posedge clk);
		cfg_index <= REG_SWIPE;
		cfg_wdata <= {4'($urandom), sw};
		@(posedge clk);
		cfg_index <= REG_SCREENS;
		cfg_wdata <= {8'($urandom), sc};
		@(posedge clk);
		cfg_we <= 1'b0;
		cooldown_cfg = cd;
		travel_min = sw;
		screen_max = sc;
	endtask

	// press, move to the end point, release exactly at the deadline
	task automatic swipe(input logic [SCREEN_W-1:0] scr,
		input logic [COORD_BITS-1:0] x0, input logic [COORD_BITS-1:0] y0,
		input logic [COORD_BITS-1:0] x1, input logic [COORD_BITS-1:0] y1,
		input logic [TIME_W-1:0] t0);
		poll(scr, 1'b1, x0, y0, t0);
		poll(scr, 1'b1, x1, y1, t0 + 1);
		poll(scr, 1'b0, x1, y1, t0 + 1 + TIME_W'(cooldown_cfg));
	endtask

	function automatic logic [COORD_BITS-1:0] fit(int v);
		if (v < 0) return '0;
		if (v > COORD_MAX) return '1;
		return v[COORD_BITS-1:0];
	endfunction

	function automatic logic [SCREEN_W-1:0] pick_screen();
		case ($urandom_range(9))
		0: return SCREEN_W'(1);
		1: return screen_max;
		2: return 8'hFF;
		3: return SCREEN_W'($urandom_range(1, 255));
		default: return SCREEN_W'($urandom_range(1, screen_max));
		endcase
	endfunction

	task automatic test_detection_off();
		poll(8'd0, 1'b1, '1, '1, '1);
		poll(8'd0, 1'b0, '0, '0, '0);
		// no stroke pending, deadline still zero: idle poll asks for refresh
		poll(8'hFF, 1'b0, '0, '0, '0);
	endtask

	task automatic test_sideways_saturation();
		swipe(8'd4, 12'd0, 12'd2048, 12'd4095, 12'd2048, 32'd1000);
		swipe(8'd1, 12'd4095, 12'd4095, 12'd0, 12'd4095, 32'd2000);
	endtask

	task automatic test_up_and_diagonal();
		swipe(8'd3, 12'd2048, 12'd0, 12'd2048, 12'd4095, 32'd3000);
		swipe(8'd3, 12'd1000, 12'd1000, 12'd1300, 12'd1300, 32'd4000);
	endtask

	task automatic test_cooldown_hold();
		poll(8'd2, 1'b1, 12'd500, 12'd500, 32'd5000);
		poll(8'd2, 1'b0, 12'd900, 12'd500, 32'd5099);
		poll(8'd2, 1'b0, 12'd900, 12'd500, 32'd5100);
	endtask

	task automatic test_zero_travel();
		configure(16'd0, 12'd0, 8'd4);
		poll(8'd2, 1'b1, 12'd7, 12'd7, 32'd6000);
		poll(8'd2, 1'b0, 12'd7, 12'd7, 32'd6000);
	endtask

	task automatic test_deadline_wrap();
		configure(16'hFFFF, 12'hFFF, 8'hFF);
		poll(8'hFF, 1'b1, 12'd0, 12'd0, 32'hFFFF_FFF0);
		poll(8'hFF, 1'b1, 12'd4095, 12'd0, 32'hFFFF_FFF1);
		poll(8'hFF, 1'b0, 12'd0, 12'd0, 32'hFFFF_FFFF);
	endtask

	task automatic random_stroke();
		logic [SCREEN_W-1:0] scr;
		logic [COORD_BITS-1:0] sx, sy;
		logic [TIME_W-1:0] touch_at;
		int reach, dx, dy;
		scr = pick_screen();
		sx = COORD_BITS'($urandom_range(COORD_MAX));
		sy = COORD_BITS'($urandom_range(COORD_MAX));
		reach = ($urandom_range(7) == 0) ? $urandom_range(COORD_MAX) : $urandom_range(700);
		case ($urandom_range(5))
		0: begin
			dx = reach;
			dy = int'($urandom_range(reach)) - reach / 2;
		end
		1: begin
			dx = -reach;
			dy = int'($urandom_range(reach)) - reach / 2;
		end
		2: begin
			dy = reach;
			dx = int'($urandom_range(reach)) - reach / 2;
		end
		3: begin
			dy = -reach;
			dx = int'($urandom_range(reach)) - reach / 2;
		end
		4: begin
			// keep exact diagonals clear of the screen edge
			reach = reach % 701;
			sx = COORD_BITS'($urandom_range(700, COORD_MAX - 700));
			sy = COORD_BITS'($urandom_range(700, COORD_MAX - 700));
			dx = $urandom_range(1) ? reach : -reach;
			dy = $urandom_range(1) ? reach : -reach;
		end
		default: begin
			dx = int'($urandom_range(2 * COORD_MAX)) - COORD_MAX;
			dy = int'($urandom_range(2 * COORD_MAX)) - COORD_MAX;
		end
		endcase

		touch_at = clock_now;
		poll(scr, 1'b1, sx, sy, clock_now);
		repeat ($urandom_range(3)) begin
			if (cooldown_cfg != 0 && $urandom_range(2) == 0) begin
				clock_now = touch_at + $urandom_range(cooldown_cfg - 1);
				poll(scr, 1'b0, 12'($urandom), 12'($urandom), clock_now);
			end
			if ($urandom_range(7) == 0)
				poll(8'd0, 1'($urandom), 12'($urandom), 12'($urandom), $urandom);
			clock_now = clock_now + $urandom_range(1, 40);
			touch_at = clock_now;
			poll(scr, 1'b1, 12'($urandom), 12'($urandom), clock_now);
		end
		clock_now = clock_now + $urandom_range(1, 40);
		touch_at = clock_now;
		poll(scr, 1'b1, fit(int'(sx) + dx), fit(int'(sy) + dy), clock_now);
		clock_now = touch_at + TIME_W'(cooldown_cfg);
		if ($urandom_range(1)) clock_now = clock_now + $urandom_range(1, 5);
		poll(scr, 1'b0, 12'($urandom), 12'($urandom), clock_now);
		repeat ($urandom_range(2)) begin
			clock_now = clock_now + $urandom_range(300);
			poll(scr, 1'b0, 12'($urandom), 12'($urandom), clock_now);
		end
	endtask

	task automatic test_random_traffic();
		int target;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
			0: configure(16'd0, 12'd0, 8'd1);
			1: configure(16'hFFFF, 12'hFFF, 8'hFF);
			default: configure(COOL_W'($urandom_range(300)), SWIPE_W'($urandom_range(500)),
				SCREEN_W'($urandom_range(1, 12)));
			endcase
			// one phase runs back to back on both sides
			in_gaps = (ph != 3);
			out_stalls = (ph != 3);
			clock_now = $urandom;
			target = polls_sent + 110;
			while (polls_sent < target) begin
				if ($urandom_range(9) == 0)
					poll(($urandom_range(3) == 0) ? 8'd0 : pick_screen(), 1'($urandom),
						12'($urandom), 12'($urandom), $urandom);
				else
					random_stroke();
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_detection_off();
		test_sideways_saturation();
		test_up_and_diagonal();
		test_cooldown_hold();
		test_zero_travel();
		test_deadline_wrap();
		test_random_traffic();
		settle();
		repeat (4) @(posedge clk);
		if (faults == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

// File: touch_swipe_gesture_detector.f
rtl/tsg_pkg.sv
rtl/tsg_classify.sv
rtl/tsg_step.sv
rtl/touch_swipe_gesture_detector.sv
test/tb.sv
